FILE: hw/rtl/slab_object_pool_defines.svh
// slab_object_pool_defines.svh: assertion macros for the slab object pool.
// Macros expect clk and rst_n in scope at the point of use.
`ifndef SLAB_OBJECT_POOL_DEFINES_SVH
`define SLAB_OBJECT_POOL_DEFINES_SVH

// same-cycle implication
`define SOP_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define SOP_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

FILE: hw/rtl/sop_pkg.sv
// sop_pkg: shared widths, opcodes, status codes and register indexes
// for the slab object pool. No dependencies.
`timescale 1ns / 1ps

package sop_pkg;

    localparam int OP_W       = 2;
    localparam int IDX_W      = 8;
    localparam int REQ_W      = 16;
    localparam int STATUS_W   = 3;
    localparam int CNT_W      = 9;
    localparam int OSIZE_W    = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    typedef logic [OP_W-1:0]     op_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

    localparam op_t OP_ALLOC = 2'd0;
    localparam op_t OP_FREE  = 2'd1;
    localparam op_t OP_QUERY = 2'd2;
    localparam op_t OP_SET   = 2'd3;

    localparam status_t ST_OK        = 3'd0;
    localparam status_t ST_EMPTY     = 3'd1;
    localparam status_t ST_RANGE     = 3'd2;
    localparam status_t ST_NOT_ALLOC = 3'd3;
    localparam status_t ST_TOO_LARGE = 3'd4;

    localparam cfg_idx_t CFG_OBJECT_COUNT = 2'd0;
    localparam cfg_idx_t CFG_OBJECT_SIZE  = 2'd1;

    localparam logic [CNT_W-1:0]   COUNT_RESET  = 9'd128;
    localparam logic [OSIZE_W-1:0] OSIZE_RESET  = 13'd32;
    localparam logic [OSIZE_W-1:0] USABLE_LIMIT = 13'd4096;

endpackage

FILE: hw/rtl/sop_ram.sv
// sop_ram: generic single-port-write, single-port-read RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module sop_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

FILE: hw/rtl/slab_object_pool.sv
// slab_object_pool: hardware free-list pool for one slab of fixed-size objects.
// Depends on sop_pkg and sop_ram.
`timescale 1ns / 1ps
//
//  channel   signals                                          direction
//  config    cfg_we cfg_index cfg_data                        in, write only
//  request   in_valid in_ready opcode object_index            in
//            request_size
//  result    out_valid out_ready status granted_index         out
//            stored_size usable_size in_use_count pool_full pool_empty
//
//  Each request reads the object entry from the RAM in ST_IDLE, then
//  modifies it, writes it back and loads the result register in ST_EXEC.
//  The result register holds a finished transfer while the next request reads.
//  A full result register stalls the write-back cycle.
//  No clearing pass: a fresh-object watermark stands in for the reset chain
//  and allocated bits, so requests are taken right after reset.

module slab_object_pool #(
    parameter int MAX_OBJECTS = 256,
    parameter int SIZE_BITS   = 16
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [sop_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [sop_pkg::CFG_DATA_W-1:0] cfg_data,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [sop_pkg::OP_W-1:0]    opcode,
    input  logic [sop_pkg::IDX_W-1:0]   object_index,
    input  logic [sop_pkg::REQ_W-1:0]   request_size,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [sop_pkg::STATUS_W-1:0] status,
    output logic [sop_pkg::IDX_W-1:0]   granted_index,
    output logic [sop_pkg::REQ_W-1:0]   stored_size,
    output logic [sop_pkg::OSIZE_W-1:0] usable_size,
    output logic [sop_pkg::CNT_W-1:0]   in_use_count,
    output logic                        pool_full,
    output logic                        pool_empty
);

    import sop_pkg::*;

    localparam int AW    = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
    localparam int CMP_W = (AW > CNT_W) ? AW : CNT_W;
    localparam int EW    = 1 + AW + SIZE_BITS;
    localparam int RESET_EFF = (128 > MAX_OBJECTS) ? MAX_OBJECTS : 128;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    function automatic logic [CNT_W-1:0] clamp_count(input logic [CNT_W-1:0] c);
        logic [CNT_W-1:0] r;
        if (c == '0)
            r = CNT_W'(1);
        else if (32'(c) > MAX_OBJECTS)
            r = CNT_W'(MAX_OBJECTS);
        else
            r = c;
        return r;
    endfunction

    logic                 state_reg, state_next;
    logic [CNT_W-1:0]     count_reg;
    logic [OSIZE_W-1:0]   osize_reg;
    logic [AW-1:0]        head_reg, head_next;
    logic [CNT_W-1:0]     fresh_reg, fresh_next;
    logic [CNT_W-1:0]     in_use_reg, in_use_next;
    op_t                  op_reg;
    logic [IDX_W-1:0]     idx_reg;
    logic [REQ_W-1:0]     req_reg;

    logic                 out_valid_reg;
    status_t              status_reg, status_next;
    logic [IDX_W-1:0]     granted_reg, granted_next;
    logic [SIZE_BITS-1:0] stored_reg, stored_next;
    logic [OSIZE_W-1:0]   usable_reg, usable_next;

    logic                 ram_we;
    logic [AW-1:0]        ram_waddr;
    logic [EW-1:0]        ram_wdata;
    logic                 ram_re;
    logic [AW-1:0]        ram_raddr;
    logic [EW-1:0]        ram_rdata;

    logic [CNT_W-1:0]     cnt_eff;
    logic [CNT_W-1:0]     cfg_cnt_eff;
    logic [OSIZE_W-1:0]   usize;
    logic                 rd_alloc;
    logic [AW-1:0]        rd_next;
    logic [SIZE_BITS-1:0] rd_size;
    logic                 head_fresh;
    logic                 obj_alloc;
    logic                 idx_range;
    logic                 req_big;
    logic [SIZE_BITS-1:0] alloc_size;
    logic                 exec_go;

    sop_ram #(
        .WIDTH (EW),
        .DEPTH (MAX_OBJECTS)
    ) u_entry_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign ram_re    = in_valid && in_ready;
    assign ram_raddr = (opcode == OP_ALLOC) ? head_reg : AW'(object_index);
    assign exec_go   = (state_reg == ST_EXEC) && (!out_valid_reg || out_ready);

    always_comb
    begin
        cnt_eff     = clamp_count(count_reg);
        cfg_cnt_eff = clamp_count(cfg_data[CNT_W-1:0]);
        if (osize_reg == '0)
            usize = OSIZE_W'(1);
        else if (osize_reg > USABLE_LIMIT)
            usize = USABLE_LIMIT;
        else
            usize = osize_reg;
    end

    assign rd_alloc   = ram_rdata[EW-1];
    assign rd_next    = ram_rdata[EW-2 -: AW];
    assign rd_size    = ram_rdata[SIZE_BITS-1:0];
    // objects below the watermark were never taken since the pool was formed
    assign head_fresh = CMP_W'(head_reg) < CMP_W'(fresh_reg);
    assign obj_alloc  = (CNT_W'(idx_reg) < fresh_reg) ? 1'b0 : rd_alloc;
    assign idx_range  = CNT_W'(idx_reg) >= cnt_eff;
    assign req_big    = req_reg > REQ_W'(usize);
    assign alloc_size = (req_reg == '0) ? SIZE_BITS'(1) : req_reg[SIZE_BITS-1:0];

    always_comb
    begin
        state_next   = state_reg;
        head_next    = head_reg;
        fresh_next   = fresh_reg;
        in_use_next  = in_use_reg;
        status_next  = ST_OK;
        granted_next = idx_reg;
        stored_next  = '0;
        usable_next  = '0;
        ram_we       = 1'b0;
        ram_waddr    = AW'(idx_reg);
        ram_wdata    = ram_rdata;

        case (state_reg)
            ST_IDLE:
            begin
                if (ram_re)
                    state_next = ST_EXEC;
            end
            default:
            begin
                if (exec_go)
                    state_next = ST_IDLE;
            end
        endcase

        case (op_reg)
            OP_ALLOC:
            begin
                if (req_big)
                    status_next = ST_TOO_LARGE;
                else if (in_use_reg >= cnt_eff)
                    status_next = ST_EMPTY;
                else
                begin
                    ram_we    = exec_go;
                    ram_waddr = head_reg;
                    ram_wdata = {1'b1, rd_next, alloc_size};
                    if (head_fresh)
                    begin
                        head_next  = (head_reg == '0) ? '0 : head_reg - 1'b1;
                        fresh_next = CNT_W'(head_reg);
                    end
                    else
                    begin
                        head_next = rd_next;
                    end
                    in_use_next  = in_use_reg + 1'b1;
                    granted_next = IDX_W'(head_reg);
                    stored_next  = alloc_size;
                    usable_next  = usize;
                end
            end
            default:
            begin
                if (idx_range)
                    status_next = ST_RANGE;
                else if (!obj_alloc)
                    status_next = ST_NOT_ALLOC;
                else
                begin
                    case (op_reg)
                        OP_FREE:
                        begin
                            ram_we    = exec_go;
                            ram_wdata = {1'b0, head_reg, {SIZE_BITS{1'b0}}};
                            head_next = AW'(idx_reg);
                            if (in_use_reg != '0)
                                in_use_next = in_use_reg - 1'b1;
                        end
                        OP_QUERY:
                        begin
                            stored_next = rd_size;
                            usable_next = usize;
                        end
                        default:
                        begin
                            if (req_big)
                                status_next = ST_TOO_LARGE;
                            else
                            begin
                                ram_we      = exec_go;
                                ram_wdata   = {1'b1, rd_next, req_reg[SIZE_BITS-1:0]};
                                stored_next = req_reg[SIZE_BITS-1:0];
                                usable_next = usize;
                            end
                        end
                    endcase
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= COUNT_RESET;
            osize_reg     <= OSIZE_RESET;
            head_reg      <= AW'(RESET_EFF - 1);
            fresh_reg     <= CNT_W'(RESET_EFF);
            in_use_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (exec_go)
            begin
                head_reg      <= head_next;
                fresh_reg     <= fresh_next;
                in_use_reg    <= in_use_next;
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            // re-forming the pool resets the chain and watermark
            if (cfg_we && (cfg_index == CFG_OBJECT_COUNT))
            begin
                count_reg  <= cfg_data[CNT_W-1:0];
                head_reg   <= AW'(cfg_cnt_eff - 1'b1);
                fresh_reg  <= cfg_cnt_eff;
                in_use_reg <= '0;
            end
            if (cfg_we && (cfg_index == CFG_OBJECT_SIZE))
            begin
                osize_reg <= cfg_data[OSIZE_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (ram_re)
        begin
            op_reg  <= opcode;
            idx_reg <= object_index;
            req_reg <= request_size;
        end
        if (exec_go)
        begin
            status_reg   <= status_next;
            granted_reg  <= granted_next;
            stored_reg   <= stored_next;
            usable_reg   <= usable_next;
            in_use_count <= in_use_next;
            pool_full    <= (in_use_next == cnt_eff);
            pool_empty   <= (in_use_next == '0);
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = status_reg;
    assign granted_index = granted_reg;
    assign stored_size   = REQ_W'(stored_reg);
    assign usable_size   = usable_reg;

endmodule

FILE: hw/rtl/sop_checker.sv
// sop_checker: port-level assertions for slab_object_pool, bound to the top.
// Depends on sop_pkg and slab_object_pool_defines.svh.
`timescale 1ns / 1ps
`include "slab_object_pool_defines.svh"

module sop_checker (
    input logic                        clk,
    input logic                        rst_n,
    input logic                        out_valid,
    input logic                        out_ready,
    input logic [sop_pkg::STATUS_W-1:0] status,
    input logic [sop_pkg::REQ_W-1:0]   stored_size,
    input logic [sop_pkg::OSIZE_W-1:0] usable_size,
    input logic [sop_pkg::CNT_W-1:0]   in_use_count,
    input logic                        pool_full,
    input logic                        pool_empty
);

    import sop_pkg::*;

    `SOP_ASSERT_NOW(a_full_empty_excl, out_valid, !(pool_full && pool_empty), "pool full and empty together")
    `SOP_ASSERT_NOW(a_error_zero_sizes, out_valid && (status != ST_OK), (stored_size == '0) && (usable_size == '0), "error transfer carries sizes")
    `SOP_ASSERT_NOW(a_empty_means_full, out_valid && (status == ST_EMPTY), pool_full, "pool empty status without full mark")
    `SOP_ASSERT_NEXT(a_result_held, out_valid && !out_ready, out_valid && $stable(status) && $stable(in_use_count), "stalled result changed")

endmodule

bind slab_object_pool sop_checker u_sop_checker (.*);

FILE: verif/slab_object_pool_tb.sv
// slab_object_pool_tb: self-checking bench for the slab object pool.
// Directed and random alloc/free/query/set traffic under random idling, checked
// against an in-bench free-list predictor. Depends on sop_pkg and slab_object_pool.
`timescale 1ns / 1ps

module slab_object_pool_tb;

    import sop_pkg::*;

    localparam int    MAX_SLOTS     = 256;
    localparam int    SETTLE_CYCLES = 6;
    localparam int    MAX_REPORTS   = 10;
    localparam time   RUN_LIMIT     = 10_000_000;
    localparam cfg_idx_t CFG_SPARE_A = 2'd2;
    localparam cfg_idx_t CFG_SPARE_B = 2'd3;

    typedef enum int {RX_ALWAYS, RX_COIN, RX_PATTERN, RX_SPARSE} rx_mode_t;

    typedef struct packed {
        status_t              status;
        logic [IDX_W-1:0]     granted_index;
        logic [REQ_W-1:0]     stored_size;
        logic [OSIZE_W-1:0]   usable_size;
        logic [CNT_W-1:0]     in_use_count;
        logic                 pool_full;
        logic                 pool_empty;
    } pool_result_t;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    logic [OP_W-1:0]        opcode = '0;
    logic [IDX_W-1:0]       object_index = '0;
    logic [REQ_W-1:0]       request_size = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    logic [STATUS_W-1:0]    status;
    logic [IDX_W-1:0]       granted_index;
    logic [REQ_W-1:0]       stored_size;
    logic [OSIZE_W-1:0]     usable_size;
    logic [CNT_W-1:0]       in_use_count;
    logic                   pool_full;
    logic                   pool_empty;

    // predictor state
    logic [CNT_W-1:0]       pool_count_reg;
    logic [OSIZE_W-1:0]     pool_size_reg;
    logic [8:0]             free_head;
    logic [8:0]             next_free [MAX_SLOTS];
    bit                     slot_taken [MAX_SLOTS];
    logic [REQ_W-1:0]       slot_size [MAX_SLOTS];
    int unsigned            slots_in_use;

    pool_result_t           pending_results [$];
    int unsigned            fail_count = 0;
    bit                     valid_held = 1'b0;
    int unsigned            burst_left = 0;
    int unsigned            hold_off_left = 0;

    slab_object_pool DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_valid),
        .in_ready      (in_ready),
        .opcode        (opcode),
        .object_index  (object_index),
        .request_size  (request_size),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .status        (status),
        .granted_index (granted_index),
        .stored_size   (stored_size),
        .usable_size   (usable_size),
        .in_use_count  (in_use_count),
        .pool_full     (pool_full),
        .pool_empty    (pool_empty)
    );

    always #6 clk = ~clk;

    function automatic int unsigned live_count();
        int unsigned c;
        c = 32'(pool_count_reg);
        if (c == 0) c = 1;
        if (c > MAX_SLOTS) c = MAX_SLOTS;
        return c;
    endfunction

    function automatic int unsigned live_size();
        int unsigned s;
        s = 32'(pool_size_reg);
        if (s == 0) s = 1;
        if (s > 32'(USABLE_LIMIT)) s = 32'(USABLE_LIMIT);
        return s;
    endfunction

    function automatic void rebuild_free_list();
        free_head = 9'(live_count() - 1);
        for (int i = 0; i < MAX_SLOTS; i++)
        begin
            next_free[i]  = (i == 0) ? 9'd0 : 9'(i - 1);
            slot_taken[i] = 1'b0;
            slot_size[i]  = '0;
        end
        slots_in_use = 0;
    endfunction

    function automatic void apply_register_write(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_OBJECT_COUNT)
        begin
            pool_count_reg = data[CNT_W-1:0];
            rebuild_free_list();
        end
        else if (idx == CFG_OBJECT_SIZE)
        begin
            pool_size_reg = data[OSIZE_W-1:0];
        end
    endfunction

    function automatic pool_result_t predict_pool_op(op_t op, logic [IDX_W-1:0] idx,
                                                     logic [REQ_W-1:0] req);
        pool_result_t r;
        int unsigned count;
        int unsigned usize;
        int unsigned obj;
        count = live_count();
        usize = live_size();
        r = '0;
        r.status = ST_OK;
        r.granted_index = idx;
        if (op == OP_ALLOC)
        begin
            if (32'(req) > usize)
                r.status = ST_TOO_LARGE;
            else if (slots_in_use >= count)
                r.status = ST_EMPTY;
            else
            begin
                obj = 32'(free_head) % MAX_SLOTS;
                free_head = next_free[obj];
                slot_taken[obj] = 1'b1;
                slot_size[obj] = (req == 0) ? 16'd1 : req;
                slots_in_use++;
                r.granted_index = obj[IDX_W-1:0];
                r.stored_size = slot_size[obj];
                r.usable_size = usize[OSIZE_W-1:0];
            end
        end
        else if (32'(idx) >= count)
            r.status = ST_RANGE;
        else if (!slot_taken[idx])
            r.status = ST_NOT_ALLOC;
        else if (op == OP_FREE)
        begin
            slot_taken[idx] = 1'b0;
            slot_size[idx] = '0;
            next_free[idx] = free_head;
            free_head = {1'b0, idx};
            if (slots_in_use > 0) slots_in_use--;
        end
        else if (op == OP_QUERY)
        begin
            r.stored_size = slot_size[idx];
            r.usable_size = usize[OSIZE_W-1:0];
        end
        else
        begin
            if (32'(req) > usize)
                r.status = ST_TOO_LARGE;
            else
            begin
                slot_size[idx] = req;
                r.stored_size = req;
                r.usable_size = usize[OSIZE_W-1:0];
            end
        end
        r.in_use_count = slots_in_use[CNT_W-1:0];
        r.pool_full = (slots_in_use == count);
        r.pool_empty = (slots_in_use == 0);
        return r;
    endfunction

    // one request transfer; sender idles in random bursts and gaps
    task automatic send_request(op_t op, logic [IDX_W-1:0] idx, logic [REQ_W-1:0] req);
        int unsigned gap;
        bit taken;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
        end
        if (gap > 0)
        begin
            if (valid_held) in_valid <= 1'b0;
            valid_held = 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid     <= 1'b1;
        opcode       <= op;
        object_index <= idx;
        request_size <= req;
        valid_held = 1'b1;
        do
        begin
            @(negedge clk);
            taken = in_ready;
            @(posedge clk);
        end
        while (!taken);
        pending_results.push_back(predict_pool_op(op, idx, req));
        burst_left--;
    endtask

    task automatic release_request();
        if (valid_held) in_valid <= 1'b0;
        valid_held = 1'b0;
    endtask

    task automatic wait_for_results();
        release_request();
        while (pending_results.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_register(cfg_idx_t idx, logic [CFG_DATA_W-1:0] data);
        wait_for_results();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        apply_register_write(idx, data);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    function automatic logic [REQ_W-1:0] pick_request_size();
        int unsigned usize;
        int unsigned pick;
        usize = live_size();
        pick = $urandom_range(0, 9);
        if (pick < 7) return REQ_W'($urandom_range(0, usize));
        if (pick < 8) return REQ_W'(usize + $urandom_range(1, 3));
        return REQ_W'($urandom_range(0, 65535));
    endfunction

    function automatic logic [IDX_W-1:0] pick_object_index();
        int unsigned held [$];
        int unsigned pick;
        int unsigned count;
        count = live_count();
        for (int i = 0; i < count; i++)
            if (slot_taken[i]) held.push_back(i);
        pick = $urandom_range(0, 99);
        if (pick < 70 && held.size() > 0)
            return IDX_W'(held[$urandom_range(0, held.size() - 1)]);
        if (pick < 88) return IDX_W'($urandom_range(0, count - 1));
        return IDX_W'($urandom_range(0, 255));
    endfunction

    task automatic test_reset_state();
        send_request(OP_ALLOC, 8'd0, 16'd0);
        send_request(OP_ALLOC, 8'd0, 16'd32);
        send_request(OP_ALLOC, 8'd0, 16'd33);
        send_request(OP_ALLOC, 8'hff, 16'hffff);
        send_request(OP_QUERY, 8'd127, 16'd0);
        send_request(OP_SET, 8'd126, 16'd0);
        send_request(OP_SET, 8'd126, 16'd40);
        send_request(OP_QUERY, 8'd5, 16'd0);
        send_request(OP_FREE, 8'd200, 16'd0);
        send_request(OP_QUERY, 8'd255, 16'd0);
        send_request(OP_SET, 8'd128, 16'd1);
        send_request(OP_FREE, 8'd127, 16'd0);
        send_request(OP_FREE, 8'd127, 16'd0);
        send_request(OP_ALLOC, 8'd0, 16'd7);
    endtask

    task automatic test_config_extremes();
        write_register(CFG_OBJECT_COUNT, 13'd1);
        write_register(CFG_OBJECT_SIZE, 13'd0);
        send_request(OP_ALLOC, 8'd0, 16'd2);
        send_request(OP_ALLOC, 8'd0, 16'd1);
        send_request(OP_ALLOC, 8'd0, 16'd2);
        send_request(OP_ALLOC, 8'd0, 16'd0);
        send_request(OP_FREE, 8'd1, 16'd0);
        send_request(OP_FREE, 8'd0, 16'd0);
        write_register(CFG_OBJECT_COUNT, 13'd0);
        send_request(OP_ALLOC, 8'd0, 16'd1);
        write_register(CFG_OBJECT_SIZE, 13'h1fff);
        write_register(CFG_OBJECT_COUNT, 13'h1fff);
        send_request(OP_ALLOC, 8'd0, 16'd4096);
        send_request(OP_ALLOC, 8'd0, 16'd4097);
        send_request(OP_SET, 8'd255, 16'd4096);
        write_register(CFG_SPARE_A, 13'($urandom_range(0, 8191)));
        write_register(CFG_SPARE_B, 13'h1fff);
        send_request(OP_QUERY, 8'd255, 16'd0);
        write_register(CFG_OBJECT_SIZE, 13'd100);
        send_request(OP_QUERY, 8'd255, 16'd0);
        send_request(OP_SET, 8'd255, 16'd101);
    endtask

    task automatic test_random_traffic();
        logic [CFG_DATA_W-1:0] counts [8] = '{13'd256, 13'd1, 13'd8, 13'd300,
                                              13'd2, 13'd0, 13'd37, 13'd128};
        logic [CFG_DATA_W-1:0] sizes  [8] = '{13'd4096, 13'd1, 13'd64, 13'd8191,
                                              13'd4095, 13'd0, 13'd200, 13'd32};
        int unsigned alloc_pct;
        int unsigned pick;
        op_t op;
        for (int p = 0; p < 8; p++)
        begin
            write_register(CFG_OBJECT_COUNT, counts[p]);
            write_register(CFG_OBJECT_SIZE, sizes[p]);
            for (int n = 0; n < 50; n++)
            begin
                if (n == 25) wait_for_results();
                alloc_pct = (n < 25) ? 65 : 30;
                pick = $urandom_range(0, 99);
                if (pick < alloc_pct)
                    op = OP_ALLOC;
                else if (pick < alloc_pct + (100 - alloc_pct) / 2)
                    op = OP_FREE;
                else if ($urandom_range(0, 1) == 0)
                    op = OP_QUERY;
                else
                    op = OP_SET;
                send_request(op, (op == OP_ALLOC) ? 8'($urandom_range(0, 255))
                                                  : pick_object_index(),
                             pick_request_size());
            end
        end
    endtask

    // receiver holds off at the start of allocating the whole slab and at the start of freeing it in random order
    task automatic test_fill_under_backpressure();
        int unsigned order [$];
        int unsigned j;
        int unsigned tmp;
        write_register(CFG_OBJECT_COUNT, 13'd256);
        write_register(CFG_OBJECT_SIZE, 13'd4096);
        hold_off_left = 150;
        for (int n = 0; n < 258; n++)
            send_request(OP_ALLOC, 8'($urandom_range(0, 255)), 16'($urandom_range(0, 4096)));
        for (int i = 0; i < MAX_SLOTS; i++) order.push_back(i);
        for (int i = MAX_SLOTS - 1; i > 0; i--)
        begin
            j = $urandom_range(0, i);
            tmp = order[i];
            order[i] = order[j];
            order[j] = tmp;
        end
        hold_off_left = 80;
        foreach (order[i])
        begin
            send_request(OP_FREE, order[i][IDX_W-1:0], 16'($urandom_range(0, 65535)));
            if (i == 100) send_request(OP_FREE, order[i][IDX_W-1:0], 16'd0);
        end
        for (int n = 0; n < 40; n++)
            send_request(($urandom_range(0, 1) == 0) ? OP_ALLOC : OP_QUERY,
                         pick_object_index(), pick_request_size());
        wait_for_results();
    endtask

    // receiver: own stall pattern plus long hold-offs on request
    initial
    begin
        rx_mode_t mode;
        int unsigned mode_left;
        int unsigned phase;
        logic [7:0] pattern;
        mode = RX_ALWAYS;
        mode_left = 0;
        phase = 0;
        pattern = 8'hff;
        forever
        begin
            @(posedge clk);
            if (mode_left == 0)
            begin
                mode = rx_mode_t'($urandom_range(0, 3));
                mode_left = $urandom_range(20, 200);
                pattern = 8'($urandom_range(1, 255));
            end
            mode_left--;
            phase++;
            if (hold_off_left > 0)
            begin
                hold_off_left--;
                out_ready <= 1'b0;
            end
            else
            begin
                case (mode)
                    RX_ALWAYS:  out_ready <= 1'b1;
                    RX_COIN:    out_ready <= 1'($urandom_range(0, 1));
                    RX_PATTERN: out_ready <= pattern[phase % 8];
                    default:    out_ready <= ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // result checker: outputs are stable at the falling edge before the transfer edge
    initial
    begin
        pool_result_t got;
        pool_result_t want;
        forever
        begin
            @(negedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                got = '{status, granted_index, stored_size, usable_size,
                        in_use_count, pool_full, pool_empty};
                if (pending_results.size() == 0)
                begin
                    if (fail_count < MAX_REPORTS)
                        $display("unexpected result at %0t: st=%0d idx=%0d sz=%0d us=%0d cnt=%0d",
                                 $realtime, got.status, got.granted_index, got.stored_size,
                                 got.usable_size, got.in_use_count);
                    fail_count++;
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        if (fail_count < MAX_REPORTS)
                            $display({"mismatch at %0t: expected st=%0d idx=%0d sz=%0d us=%0d ",
                                      "cnt=%0d full=%0b empty=%0b, got st=%0d idx=%0d sz=%0d ",
                                      "us=%0d cnt=%0d full=%0b empty=%0b"},
                                     $realtime, want.status, want.granted_index,
                                     want.stored_size, want.usable_size, want.in_use_count,
                                     want.pool_full, want.pool_empty, got.status,
                                     got.granted_index, got.stored_size, got.usable_size,
                                     got.in_use_count, got.pool_full, got.pool_empty);
                        fail_count++;
                    end
                end
            end
        end
    end

    initial
    begin
        #RUN_LIMIT;
        $display("slab_object_pool test failed");
        $finish;
    end

    initial
    begin
        pool_count_reg = COUNT_RESET;
        pool_size_reg  = OSIZE_RESET;
        rebuild_free_list();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_reset_state();
        test_config_extremes();
        test_random_traffic();
        test_fill_under_backpressure();
        wait_for_results();
        repeat (10) @(posedge clk);
        if (fail_count == 0)
            $display("slab_object_pool test passed");
        else
            $display("slab_object_pool test failed");
        $finish;
    end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/sop_pkg.sv
hw/rtl/sop_ram.sv
hw/rtl/slab_object_pool.sv
hw/rtl/sop_checker.sv
verif/slab_object_pool_tb.sv
